// File: src/rpbrc_pkg.sv
// Shared types, constants and node functions for the black run counter.
`timescale 1ns / 1ps
package rpbrc_pkg;

  localparam int unsigned LEAVES = 65536;
  localparam int unsigned LVLS   = 16;
  localparam int unsigned DEPTH  = 2 * LEAVES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned BND_W  = ADDR_W + 1;
  localparam int unsigned LVL_W  = $clog2(LVLS + 1);

  localparam logic [1:0] COL_NONE  = 2'd0;
  localparam logic [1:0] COL_BLACK = 2'd1;
  localparam logic [1:0] COL_WHITE = 2'd2;

  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_LOAD   = 4'd2;
  localparam logic [3:0] OP_PREAD  = 4'd3;
  localparam logic [3:0] OP_PWR_L  = 4'd4;
  localparam logic [3:0] OP_PWR_R  = 4'd5;
  localparam logic [3:0] OP_PWR_N  = 4'd6;
  localparam logic [3:0] OP_PNEXT  = 4'd7;
  localparam logic [3:0] OP_APPLY  = 4'd8;
  localparam logic [3:0] OP_UREADA = 4'd9;
  localparam logic [3:0] OP_UREADB = 4'd10;
  localparam logic [3:0] OP_UWR    = 4'd11;
  localparam logic [3:0] OP_UNEXT  = 4'd12;
  localparam logic [3:0] OP_ROOT   = 4'd13;
  localparam logic [3:0] OP_OUT    = 4'd14;

  typedef struct packed {
    logic        paint_black;
    logic [15:0] range_start;
    logic [16:0] range_end;
  } in_word_t;

  typedef struct packed {
    logic [15:0] black_runs;
    logic [16:0] black_length;
  } out_word_t;

  typedef struct packed {
    logic [16:0] len;
    logic [15:0] runs;
    logic [1:0]  lcol;
    logic [1:0]  rcol;
    logic [1:0]  pend;
  } node_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic hit;
    logic pend_set;
    logic down_last;
    logic apply_more;
    logic up_last;
    logic out_free;
  } stat_t;

  function automatic node_t node_apply(logic [1:0] tag, logic [16:0] span);
    node_t n;
    n.pend = tag;
    if (tag == COL_BLACK) begin
      n.len  = span;
      n.runs = 16'd1;
      n.lcol = COL_BLACK;
      n.rcol = COL_BLACK;
    end else begin
      n.len  = 17'd0;
      n.runs = 16'd0;
      n.lcol = COL_WHITE;
      n.rcol = COL_WHITE;
    end
    return n;
  endfunction

  function automatic node_t node_pull(node_t a, node_t b);
    node_t n;
    n.len  = a.len + b.len;
    n.runs = a.runs + b.runs;
    if (a.rcol == COL_BLACK && b.lcol == COL_BLACK) begin
      n.runs = n.runs - 16'd1;
    end
    n.lcol = a.lcol;
    n.rcol = b.rcol;
    n.pend = COL_NONE;
    return n;
  endfunction

endpackage

// File: src/range_paint_black_run_counter.sv
// Top level: paints ranges of a line and reports black run count and length.
//
// Input word: paint_black, range_start, range_end (exclusive), on in_valid_i /
// in_ready_o. Output word: black_runs, black_length for the whole line after
// the paint, one per input, on out_valid_o / out_ready_i.
// The line is a lazy segment tree of 131072 nodes in one RAM with a single
// write port. An empty range goes straight to the root read. Any other word
// takes a push pass over the boundary nodes on 16 levels, an apply pass over
// each covering node and level step, and a pull pass over the boundary nodes.
// After reset the block sweeps the node RAM to zero, one node a cycle, over
// all 131072 nodes, with in_ready_o low.
// The result sits in an output register; a new word is accepted while it
// waits, and the walk holds at its end until the register is free.
`timescale 1ns / 1ps
module range_paint_black_run_counter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rpbrc_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rpbrc_pkg::out_word_t out_data_o
);

  rpbrc_pkg::cmd_t  cmd;
  rpbrc_pkg::stat_t stat;

  rpbrc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rpbrc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: src/rpbrc_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module rpbrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rpbrc_datapath.sv
// Datapath: node RAM, tree walk registers and result register.
`timescale 1ns / 1ps
module rpbrc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpbrc_pkg::cmd_t     cmd_i,
  output rpbrc_pkg::stat_t    stat_o,
  input  rpbrc_pkg::in_word_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rpbrc_pkg::out_word_t out_data_o
);

  localparam int unsigned AW = rpbrc_pkg::ADDR_W;
  localparam int unsigned BW = rpbrc_pkg::BND_W;
  localparam int unsigned LW = rpbrc_pkg::LVL_W;

  logic [1:0]    tag_q, tag_d;
  logic [BW-1:0] lb_q, lb_d, rb_q, rb_d, lw_q, lw_d, rw_q, rw_d;
  logic [LW-1:0] lvl_q, lvl_d, alvl_q, alvl_d;
  logic          side_q, side_d;
  logic [AW-1:0] clr_q, clr_d;
  rpbrc_pkg::node_t a_q, a_d;
  logic          out_valid_q, out_valid_d;
  rpbrc_pkg::out_word_t out_q, out_d;

  logic [16:0]   end_clip;
  logic [BW-1:0] base, low, mask, cur;
  logic [AW-1:0] node;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  rpbrc_pkg::node_t wdata, rdata, rd_clr;
  logic [$bits(rpbrc_pkg::node_t)-1:0] rdata_raw;

  assign end_clip = (in_data_i.range_end > 17'(rpbrc_pkg::LEAVES)) ?
                    17'(rpbrc_pkg::LEAVES) : in_data_i.range_end;
  assign base  = side_q ? (rb_q - BW'(1)) : lb_q;
  assign low   = side_q ? rb_q : lb_q;
  assign mask  = (BW'(1) << lvl_q) - BW'(1);
  assign cur   = base >> lvl_q;
  assign node  = cur[AW-1:0];
  assign rdata = rpbrc_pkg::node_t'(rdata_raw);

  always_comb begin
    rd_clr      = rdata;
    rd_clr.pend = rpbrc_pkg::COL_NONE;
  end

  always_comb begin
    stat_o.clr_last   = (clr_q == {AW{1'b1}});
    stat_o.empty      = ({1'b0, in_data_i.range_start} >= end_clip);
    stat_o.hit        = ((low & mask) != '0);
    stat_o.pend_set   = (rdata.pend != rpbrc_pkg::COL_NONE);
    stat_o.down_last  = (lvl_q == LW'(1)) && side_q;
    stat_o.apply_more = (lw_q < rw_q);
    stat_o.up_last    = (lvl_q == LW'(rpbrc_pkg::LVLS)) && side_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    tag_d  = tag_q;
    lb_d   = lb_q;
    rb_d   = rb_q;
    lw_d   = lw_q;
    rw_d   = rw_q;
    lvl_d  = lvl_q;
    alvl_d = alvl_q;
    side_d = side_q;
    clr_d  = clr_q;
    a_d    = a_q;
    out_d  = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we    = 1'b0;
    re    = 1'b0;
    waddr = node;
    raddr = node;
    wdata = rd_clr;
    unique case (cmd_i.op)
      rpbrc_pkg::OP_NOP: begin
      end
      rpbrc_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
      end
      rpbrc_pkg::OP_LOAD: begin
        tag_d  = in_data_i.paint_black ? rpbrc_pkg::COL_BLACK : rpbrc_pkg::COL_WHITE;
        lb_d   = BW'(in_data_i.range_start) + BW'(rpbrc_pkg::LEAVES);
        rb_d   = BW'(end_clip) + BW'(rpbrc_pkg::LEAVES);
        lvl_d  = LW'(rpbrc_pkg::LVLS);
        side_d = 1'b0;
      end
      rpbrc_pkg::OP_PREAD: begin
        re = 1'b1;
      end
      rpbrc_pkg::OP_PWR_L: begin
        we    = 1'b1;
        waddr = {node[AW-2:0], 1'b0};
        wdata = rpbrc_pkg::node_apply(rdata.pend, 17'(1) << (lvl_q - LW'(1)));
      end
      rpbrc_pkg::OP_PWR_R: begin
        we    = 1'b1;
        waddr = {node[AW-2:0], 1'b1};
        wdata = rpbrc_pkg::node_apply(rdata.pend, 17'(1) << (lvl_q - LW'(1)));
      end
      rpbrc_pkg::OP_PWR_N: begin
        we = 1'b1;
      end
      rpbrc_pkg::OP_PNEXT: begin
        side_d = !side_q;
        if (side_q) begin
          lvl_d = lvl_q - LW'(1);
        end
        if (stat_o.down_last) begin
          lvl_d  = LW'(1);
          lw_d   = lb_q;
          rw_d   = rb_q;
          alvl_d = '0;
        end
      end
      rpbrc_pkg::OP_APPLY: begin
        if (lw_q[0]) begin
          we    = 1'b1;
          waddr = lw_q[AW-1:0];
          wdata = rpbrc_pkg::node_apply(tag_q, 17'(1) << alvl_q);
          lw_d  = lw_q + BW'(1);
        end else if (rw_q[0]) begin
          we    = 1'b1;
          rw_d  = rw_q - BW'(1);
          waddr = rw_d[AW-1:0];
          wdata = rpbrc_pkg::node_apply(tag_q, 17'(1) << alvl_q);
        end else begin
          lw_d   = lw_q >> 1;
          rw_d   = rw_q >> 1;
          alvl_d = alvl_q + LW'(1);
        end
      end
      rpbrc_pkg::OP_UREADA: begin
        re    = 1'b1;
        raddr = {node[AW-2:0], 1'b0};
      end
      rpbrc_pkg::OP_UREADB: begin
        re    = 1'b1;
        raddr = {node[AW-2:0], 1'b1};
        a_d   = rdata;
      end
      rpbrc_pkg::OP_UWR: begin
        we    = 1'b1;
        wdata = rpbrc_pkg::node_pull(a_q, rdata);
      end
      rpbrc_pkg::OP_UNEXT: begin
        side_d = !side_q;
        if (side_q) begin
          lvl_d = lvl_q + LW'(1);
        end
      end
      rpbrc_pkg::OP_ROOT: begin
        re    = 1'b1;
        raddr = AW'(1);
      end
      rpbrc_pkg::OP_OUT: begin
        out_valid_d        = 1'b1;
        out_d.black_runs   = rdata.runs;
        out_d.black_length = rdata.len;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      lvl_q       <= '0;
      side_q      <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      lvl_q       <= lvl_d;
      side_q      <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    lb_q   <= lb_d;
    rb_q   <= rb_d;
    lw_q   <= lw_d;
    rw_q   <= rw_d;
    alvl_q <= alvl_d;
    a_q    <= a_d;
    out_q  <= out_d;
  end

  rpbrc_ram #(
    .WIDTH($bits(rpbrc_pkg::node_t)),
    .DEPTH(rpbrc_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/rpbrc_ctrl.sv
// Controller state machine sequencing push, apply and pull passes.
`timescale 1ns / 1ps
module rpbrc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rpbrc_pkg::stat_t stat_i,
  output rpbrc_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PSEL  = 4'd2;
  localparam logic [3:0] ST_PCHK  = 4'd3;
  localparam logic [3:0] ST_PWR_R = 4'd4;
  localparam logic [3:0] ST_PWR_N = 4'd5;
  localparam logic [3:0] ST_PNEXT = 4'd6;
  localparam logic [3:0] ST_APPLY = 4'd7;
  localparam logic [3:0] ST_USEL  = 4'd8;
  localparam logic [3:0] ST_UB    = 4'd9;
  localparam logic [3:0] ST_UWR   = 4'd10;
  localparam logic [3:0] ST_UNEXT = 4'd11;
  localparam logic [3:0] ST_ROOT  = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = rpbrc_pkg::OP_NOP;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = rpbrc_pkg::OP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rpbrc_pkg::OP_LOAD;
          state_d  = stat_i.empty ? ST_ROOT : ST_PSEL;
        end
      end
      ST_PSEL: begin
        if (stat_i.hit) begin
          cmd_o.op = rpbrc_pkg::OP_PREAD;
          state_d  = ST_PCHK;
        end else begin
          state_d = ST_PNEXT;
        end
      end
      ST_PCHK: begin
        if (stat_i.pend_set) begin
          cmd_o.op = rpbrc_pkg::OP_PWR_L;
          state_d  = ST_PWR_R;
        end else begin
          state_d = ST_PNEXT;
        end
      end
      ST_PWR_R: begin
        cmd_o.op = rpbrc_pkg::OP_PWR_R;
        state_d  = ST_PWR_N;
      end
      ST_PWR_N: begin
        cmd_o.op = rpbrc_pkg::OP_PWR_N;
        state_d  = ST_PNEXT;
      end
      ST_PNEXT: begin
        cmd_o.op = rpbrc_pkg::OP_PNEXT;
        state_d  = stat_i.down_last ? ST_APPLY : ST_PSEL;
      end
      ST_APPLY: begin
        if (stat_i.apply_more) begin
          cmd_o.op = rpbrc_pkg::OP_APPLY;
        end else begin
          state_d = ST_USEL;
        end
      end
      ST_USEL: begin
        if (stat_i.hit) begin
          cmd_o.op = rpbrc_pkg::OP_UREADA;
          state_d  = ST_UB;
        end else begin
          state_d = ST_UNEXT;
        end
      end
      ST_UB: begin
        cmd_o.op = rpbrc_pkg::OP_UREADB;
        state_d  = ST_UWR;
      end
      ST_UWR: begin
        cmd_o.op = rpbrc_pkg::OP_UWR;
        state_d  = ST_UNEXT;
      end
      ST_UNEXT: begin
        cmd_o.op = rpbrc_pkg::OP_UNEXT;
        state_d  = stat_i.up_last ? ST_ROOT : ST_USEL;
      end
      ST_ROOT: begin
        cmd_o.op = rpbrc_pkg::OP_ROOT;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = rpbrc_pkg::OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sim/tb_line_checker.sv
// Line checker: predicts black run totals per paint and compares the output words.
`timescale 1ns / 1ps
module tb_line_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  rpbrc_pkg::in_word_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  rpbrc_pkg::out_word_t out_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int unsigned SPAN  = 65536;
  localparam int unsigned NNODE = 2 * SPAN;

  logic [16:0] seg_len  [NNODE];
  logic [15:0] seg_runs [NNODE];
  logic [1:0]  seg_lcol [NNODE];
  logic [1:0]  seg_rcol [NNODE];
  logic [1:0]  seg_pend [NNODE];

  rpbrc_pkg::out_word_t line_totals_q[$];
  int err_q  = 0;
  int pend_q = 0;

  initial begin
    for (int i = 0; i < NNODE; i++) begin
      seg_len[i]  = '0;
      seg_runs[i] = '0;
      seg_lcol[i] = rpbrc_pkg::COL_NONE;
      seg_rcol[i] = rpbrc_pkg::COL_NONE;
      seg_pend[i] = rpbrc_pkg::COL_NONE;
    end
  end

  assign errors_o  = err_q;
  assign pending_o = pend_q;

  function automatic void set_colour(int unsigned nd, int unsigned span, logic [1:0] tag);
    if (tag == rpbrc_pkg::COL_BLACK) begin
      seg_len[nd]  = span[16:0];
      seg_runs[nd] = 16'd1;
    end else if (tag == rpbrc_pkg::COL_WHITE) begin
      seg_len[nd]  = '0;
      seg_runs[nd] = '0;
    end else begin
      return;
    end
    seg_lcol[nd] = tag;
    seg_rcol[nd] = tag;
    seg_pend[nd] = tag;
  endfunction

  function automatic void paint_line(int unsigned nd, int unsigned lo, int unsigned hi,
                                     int unsigned l, int unsigned r, logic [1:0] tag);
    int unsigned mid;
    int unsigned a;
    int unsigned b;
    mid = lo + (hi - lo) / 2;
    a = 2 * nd;
    b = a + 1;
    if (hi - lo > 1) begin
      set_colour(a, mid - lo, seg_pend[nd]);
      set_colour(b, hi - mid, seg_pend[nd]);
    end
    seg_pend[nd] = rpbrc_pkg::COL_NONE;
    if (l <= lo && hi <= r) begin
      set_colour(nd, hi - lo, tag);
      return;
    end
    if (hi - lo <= 1) return;
    if (l < mid) paint_line(a, lo, mid, l, r, tag);
    if (r > mid) paint_line(b, mid, hi, l, r, tag);
    seg_runs[nd] = seg_runs[a] + seg_runs[b];
    if (seg_rcol[a] == rpbrc_pkg::COL_BLACK && seg_lcol[b] == rpbrc_pkg::COL_BLACK) begin
      seg_runs[nd] = seg_runs[nd] - 16'd1;
    end
    seg_len[nd]  = seg_len[a] + seg_len[b];
    seg_lcol[nd] = seg_lcol[a];
    seg_rcol[nd] = seg_rcol[b];
  endfunction

  always @(posedge clk_i) begin
    int unsigned          lft;
    int unsigned          rgt;
    int                   bad;
    logic [1:0]           tag;
    rpbrc_pkg::out_word_t want;
    bad = 0;
    if (rst_ni && in_valid_i && in_ready_i) begin
      lft = 32'(in_data_i.range_start);
      rgt = 32'(in_data_i.range_end);
      if (rgt > SPAN) rgt = SPAN;
      tag = in_data_i.paint_black ? rpbrc_pkg::COL_BLACK : rpbrc_pkg::COL_WHITE;
      if (lft < rgt) begin
        paint_line(1, 0, SPAN, lft, rgt, tag);
      end
      want.black_runs   = seg_runs[1];
      want.black_length = seg_len[1];
      line_totals_q.push_back(want);
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (line_totals_q.size() == 0) begin
        $error("output word with no paint outstanding");
        bad = bad + 1;
      end else begin
        want = line_totals_q.pop_front();
        if (want.black_runs !== out_data_i.black_runs) begin
          $error("black_runs expected %0d actual %0d", want.black_runs,
                 out_data_i.black_runs);
          bad = bad + 1;
        end
        if (want.black_length !== out_data_i.black_length) begin
          $error("black_length expected %0d actual %0d", want.black_length,
                 out_data_i.black_length);
          bad = bad + 1;
        end
      end
    end
    if (bad != 0) begin
      err_q <= err_q + bad;
    end
    pend_q <= line_totals_q.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: drives paint words, throttles the output side and gives the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rpbrc_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rpbrc_pkg::out_word_t out_data;
  int                   errors;
  int                   pending;
  int                   idle_cycles = 0;
  int                   words_out = 0;

  always #5 clk_i = ~clk_i;

  range_paint_black_run_counter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  tb_line_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return $urandom_range(0, 2);
    if (sel < 18) return $urandom_range(3, 12);
    return $urandom_range(30, 300);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_paint(logic blk, int unsigned lft, int unsigned rgt, int gap);
    rpbrc_pkg::in_word_t word;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    word.paint_black = blk;
    word.range_start = lft[15:0];
    word.range_end   = rgt[16:0];
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic send_random(int gap);
    int unsigned lft;
    int unsigned rgt;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      lft = $urandom_range(0, 2047);
      rgt = lft + $urandom_range(1, 64);
    end else if (sel < 70) begin
      lft = $urandom_range(0, 65535);
      rgt = lft + $urandom_range(1, 4096);
    end else if (sel < 75) begin
      lft = $urandom_range(0, 255);
      rgt = $urandom_range(65000, 65536);
    end else if (sel < 85) begin
      lft = $urandom_range(0, 65535);
      rgt = $urandom_range(0, lft);
    end else begin
      lft = $urandom_range(65000, 65535);
      rgt = 65536;
    end
    if (rgt > 65536) rgt = 65536;
    send_paint(1'($urandom_range(0, 1)), lft, rgt, gap);
  endtask

  initial begin
    int burst;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_paint(1'b1, 0, 65536, 0);
    send_paint(1'b0, 0, 65536, 0);
    send_paint(1'b1, 0, 1, 1);
    send_paint(1'b1, 65535, 65536, 0);
    send_paint(1'b1, 10, 20, 2);
    send_paint(1'b1, 20, 30, 0);
    send_paint(1'b0, 15, 16, 0);
    send_paint(1'b1, 15, 16, 3);
    send_paint(1'b1, 40, 40, 0);
    send_paint(1'b0, 500, 100, 0);
    send_paint(1'b1, 65535, 0, 0);
    send_paint(1'b0, 65535, 65536, 1);
    send_paint(1'b1, 32767, 32769, 0);
    send_paint(1'b0, 32768, 32769, 0);
    send_paint(1'b1, 1, 65535, 0);
    send_paint(1'b0, 0, 65536, 0);
    for (int k = 0; k < 8; k++) send_paint(1'b1, 2 * k, 2 * k + 1, 0);
    send_paint(1'b1, 0, 16, 0);
    burst = 0;
    for (int n = 0; n < 750; n++) begin
      if (burst > 0) begin
        burst--;
        send_random(0);
      end else begin
        if ($urandom_range(0, 29) == 0) burst = $urandom_range(10, 40);
        send_random(pick_gap());
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    bit held;
    int len;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && words_out >= 100) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (5000) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      len = pick_gap();
      if (len > 0 && $urandom_range(0, 1)) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (len) @(negedge clk_i);
        out_ready <= 1'b1;
      end
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid && out_ready) words_out <= words_out + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
